@@ design/iqdf_pkg.sv @@
// Shared package of the I/Q DC-blocking decimating FIR filter.
// Holds sizes, register and mode codes, control structs and the saturation helper.
// Has no dependencies.
package iqdf_pkg;

    localparam int MAX_TAPS    = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int TAP_W       = $clog2(MAX_TAPS);
    localparam int CNT_W       = TAP_W + 1;
    localparam int COEF_W      = 16;
    localparam int BETA_W      = 16;
    localparam int DC_FRAC     = 16;
    localparam int COEF_FRAC   = 15;
    localparam int DC_W        = SAMPLE_BITS + DC_FRAC;
    localparam int PROD_W      = SAMPLE_BITS + COEF_W;
    localparam int ACC_W       = PROD_W + TAP_W;
    localparam int SAT_W       = 48;

    localparam int DECIM_W     = 7;
    localparam int TAPS_W      = 7;
    localparam int MAX_DECIM   = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int IN_I_LO       = 0;
    localparam int IN_Q_LO       = SAMPLE_BITS;
    localparam int IN_IDX_LO     = 2 * SAMPLE_BITS;
    localparam int IN_COEF_LO    = IN_IDX_LO + TAP_W;
    localparam int IN_FIELDS_W   = IN_COEF_LO + COEF_W;
    localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = 2 * SAMPLE_BITS;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_COEF   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DECIM = 2'd0,
        REG_TAPS  = 2'd1,
        REG_BETA  = 2'd2
    } cfg_reg_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]      coef_t;

    typedef struct packed {
        logic rotate;
        logic write;
    } chain_ctl_t;

    typedef struct packed {
        logic hit;
        logic last;
        logic active;
    } cell_sel_t;

    typedef struct packed {
        logic tap;
        logic mul;
        logic acc;
        logic clear;
        logic round;
    } mac_ctl_t;

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

    function automatic sample_t sat_sample(input logic signed [SAT_W-1:0] v);
        sample_t r;
        if (v > SAT_HI)
            r = sample_t'(SAT_HI);
        else if (v < SAT_LO)
            r = sample_t'(SAT_LO);
        else
            r = v[SAMPLE_BITS-1:0];
        return r;
    endfunction

endpackage

@@ design/iq_dc_block_decimating_fir.sv @@
// I/Q DC-blocking decimating FIR filter, top level.
// Holds the sequencer, configuration registers, coefficient table and output register.
// Depends on iqdf_pkg, iqdf_ram, iqdf_dc, iqdf_chain and iqdf_mac.
//
// Input items arrive on the s_axis channel; tuser selects a sample (I and Q) or a
// coefficient write. Results leave on the m_axis channel as one I/Q pair per
// decim_factor samples. Registers are written on the cfg channel; the user must
// write them only while the block is idle, which the block itself does not enforce.
// For a sample that completes a decimation window, the filter pass streams the
// history ring out of its head cell once, one tap per cycle into one multiplier per
// rail, with a registered coefficient table read in step.
// The result sits in an output register; the next item is taken while it waits,
// and only a further result waits for a stalled receiver.
// Reset clears the history, DC estimates, coefficients, counters and the output,
// and loads decim_factor 4, taps_in_use 64 and dc_beta 655.
module iq_dc_block_decimating_fir (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // i_sample[15:0], q_sample[31:16], coef_index[37:32], coef_value[53:38], zero pad
    input  logic [iqdf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // mode[0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // i_out[15:0], q_out[31:16]
    output logic [iqdf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [iqdf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [iqdf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import iqdf_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DC_ERR = 7'b0000010,
        ST_DC_MUL = 7'b0000100,
        ST_COMMIT = 7'b0001000,
        ST_MAC    = 7'b0010000,
        ST_ROUND  = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [DECIM_W-1:0]    decim_reg;
    logic [TAPS_W-1:0]     taps_reg;
    logic [BETA_W-1:0]     beta_reg;
    logic [TAP_W-1:0]      wpos_reg, wpos_next;
    logic [TAP_W-1:0]      phase_reg, phase_next;
    logic [TAP_W-1:0]      addr_reg, addr_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  v1_reg, v2_reg;
    logic                  coef_ok_reg;
    logic [MAX_TAPS-1:0]   coef_valid_reg;
    sample_t               si_reg, sq_reg;
    logic                  out_valid_reg, out_valid_next;
    sample_t               out_i_reg, out_q_reg;

    logic                  in_xfer, cfg_xfer;
    logic                  in_mode;
    sample_t               in_i, in_q;
    logic [TAP_W-1:0]      in_idx;
    coef_t                 in_coef;
    logic                  coef_wr;

    logic [CNT_W-1:0]      n_use;
    logic [TAP_W-1:0]      n_last;
    logic [DECIM_W-1:0]    m_use;
    logic [TAP_W-1:0]      slot;
    logic [CNT_W-1:0]      slot_inc;
    logic                  emit;
    logic                  issue;
    logic                  out_load;

    logic [COEF_W-1:0]     ram_q;
    coef_t                 coef_eff;
    chain_ctl_t            chain_ctl;
    mac_ctl_t              mac_ctl;
    sample_t               err_i, err_q;
    sample_t               head_i, head_q;
    sample_t               res_i, res_q;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_xfer      = cfg_valid && cfg_ready;

    assign in_mode = s_axis_tuser;
    assign in_i    = s_axis_tdata[IN_I_LO +: SAMPLE_BITS];
    assign in_q    = s_axis_tdata[IN_Q_LO +: SAMPLE_BITS];
    assign in_idx  = s_axis_tdata[IN_IDX_LO +: TAP_W];
    assign in_coef = s_axis_tdata[IN_COEF_LO +: COEF_W];
    assign coef_wr = in_xfer && (in_mode == MODE_COEF);

    always_comb
    begin
        if (taps_reg == '0)
            n_use = CNT_W'(1);
        else if (taps_reg > TAPS_W'(MAX_TAPS))
            n_use = CNT_W'(MAX_TAPS);
        else
            n_use = CNT_W'(taps_reg);
        n_last = TAP_W'(n_use - CNT_W'(1));

        if (decim_reg == '0)
            m_use = DECIM_W'(1);
        else if (decim_reg > DECIM_W'(MAX_DECIM))
            m_use = DECIM_W'(MAX_DECIM);
        else
            m_use = decim_reg;

        slot     = (CNT_W'(wpos_reg) < n_use) ? wpos_reg : '0;
        slot_inc = CNT_W'(slot) + CNT_W'(1);
        emit     = !(DECIM_W'(phase_reg) + DECIM_W'(1) < m_use);
        issue    = (state_reg == ST_MAC) && (cnt_reg < n_use);
        out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);
    end

    always_comb
    begin
        state_next = state_reg;
        wpos_next  = wpos_reg;
        phase_next = phase_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (in_mode == MODE_SAMPLE))
                    state_next = ST_DC_ERR;
            end
            ST_DC_ERR:
            begin
                state_next = ST_DC_MUL;
            end
            ST_DC_MUL:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                wpos_next = (slot_inc == n_use) ? '0 : slot_inc[TAP_W-1:0];
                if (emit)
                begin
                    phase_next = '0;
                    addr_next  = slot;
                    cnt_next   = '0;
                    state_next = ST_MAC;
                end
                else
                begin
                    phase_next = phase_reg + TAP_W'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_MAC:
            begin
                if (issue)
                begin
                    // Coefficient index runs down from the newest slot, wrapping in the ring.
                    addr_next = (addr_reg == '0) ? n_last : addr_reg - TAP_W'(1);
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
                else if (!v1_reg && !v2_reg)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            decim_reg      <= DECIM_W'(4);
            taps_reg       <= TAPS_W'(64);
            beta_reg       <= BETA_W'(655);
            wpos_reg       <= '0;
            phase_reg      <= '0;
            addr_reg       <= '0;
            cnt_reg        <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            coef_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wpos_reg      <= wpos_next;
            phase_reg     <= phase_next;
            addr_reg      <= addr_next;
            cnt_reg       <= cnt_next;
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            out_valid_reg <= out_valid_next;
            if (coef_wr)
            begin
                coef_valid_reg[in_idx] <= 1'b1;
            end
            if (cfg_xfer)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_DECIM: decim_reg <= cfg_data[DECIM_W-1:0];
                    REG_TAPS:  taps_reg  <= cfg_data[TAPS_W-1:0];
                    REG_BETA:  beta_reg  <= cfg_data[BETA_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            si_reg <= in_i;
            sq_reg <= in_q;
        end
        if (issue)
        begin
            coef_ok_reg <= coef_valid_reg[addr_reg];
        end
        if (out_load)
        begin
            out_i_reg <= res_i;
            out_q_reg <= res_q;
        end
    end

    iqdf_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (coef_wr),
        .wr_addr (in_idx),
        .wr_data (in_coef),
        .rd_en   (issue),
        .rd_addr (addr_reg),
        .rd_data (ram_q)
    );

    // Taps never written read as zero.
    assign coef_eff = coef_ok_reg ? coef_t'(ram_q) : '0;

    iqdf_dc u_dc_i (
        .clk    (clk),
        .rst_n  (rst_n),
        .beta   (beta_reg),
        .sample (si_reg),
        .err_en (state_reg == ST_DC_ERR),
        .mul_en (state_reg == ST_DC_MUL),
        .commit (state_reg == ST_COMMIT),
        .err    (err_i)
    );

    iqdf_dc u_dc_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .beta   (beta_reg),
        .sample (sq_reg),
        .err_en (state_reg == ST_DC_ERR),
        .mul_en (state_reg == ST_DC_MUL),
        .commit (state_reg == ST_COMMIT),
        .err    (err_q)
    );

    assign chain_ctl.write  = (state_reg == ST_COMMIT);
    assign chain_ctl.rotate = issue;

    iqdf_chain u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (chain_ctl),
        .slot   (slot),
        .n_last (n_last),
        .wr_i   (err_i),
        .wr_q   (err_q),
        .head_i (head_i),
        .head_q (head_q)
    );

    assign mac_ctl.tap   = issue;
    assign mac_ctl.mul   = v1_reg;
    assign mac_ctl.acc   = v2_reg;
    assign mac_ctl.clear = (state_reg == ST_COMMIT);
    assign mac_ctl.round = (state_reg == ST_ROUND);

    iqdf_mac u_mac_i (
        .clk    (clk),
        .ctl    (mac_ctl),
        .hist   (head_i),
        .coef   (coef_eff),
        .result (res_i)
    );

    iqdf_mac u_mac_q (
        .clk    (clk),
        .ctl    (mac_ctl),
        .hist   (head_q),
        .coef   (coef_eff),
        .result (res_q)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_q_reg, out_i_reg};

endmodule

@@ design/iqdf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the coefficient table.
module iqdf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/iqdf_cell.sv @@
// One history cell: holds one I and one Q sample of the ring.
// It is written from the DC stage or takes its neighbor's value during a filter pass.
// Depends on iqdf_pkg.
module iqdf_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  iqdf_pkg::chain_ctl_t ctl,
    input  iqdf_pkg::cell_sel_t  sel,
    input  iqdf_pkg::sample_t    wr_i,
    input  iqdf_pkg::sample_t    wr_q,
    input  iqdf_pkg::sample_t    next_i,
    input  iqdf_pkg::sample_t    next_q,
    input  iqdf_pkg::sample_t    head_i,
    input  iqdf_pkg::sample_t    head_q,
    output iqdf_pkg::sample_t    i_val,
    output iqdf_pkg::sample_t    q_val
);
    import iqdf_pkg::*;

    sample_t i_reg, i_next;
    sample_t q_reg, q_next;

    always_comb
    begin
        i_next = i_reg;
        q_next = q_reg;
        if (ctl.write && sel.hit)
        begin
            i_next = wr_i;
            q_next = wr_q;
        end
        else if (ctl.rotate && sel.active)
        begin
            // The last cell of the ring wraps around to the head.
            if (sel.last)
            begin
                i_next = head_i;
                q_next = head_q;
            end
            else
            begin
                i_next = next_i;
                q_next = next_q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            q_reg <= '0;
        end
        else
        begin
            i_reg <= i_next;
            q_reg <= q_next;
        end
    end

    assign i_val = i_reg;
    assign q_val = q_reg;

endmodule

@@ design/iqdf_chain.sv @@
// Row of history cells forming the sample ring of both rails.
// A filter pass rotates the active part of the ring once, streaming it out of cell 0.
// Depends on iqdf_pkg and iqdf_cell.
module iqdf_chain (
    input  logic                         clk,
    input  logic                         rst_n,
    input  iqdf_pkg::chain_ctl_t         ctl,
    input  logic [iqdf_pkg::TAP_W-1:0]   slot,
    input  logic [iqdf_pkg::TAP_W-1:0]   n_last,
    input  iqdf_pkg::sample_t            wr_i,
    input  iqdf_pkg::sample_t            wr_q,
    output iqdf_pkg::sample_t            head_i,
    output iqdf_pkg::sample_t            head_q
);
    import iqdf_pkg::*;

    sample_t cell_i [MAX_TAPS];
    sample_t cell_q [MAX_TAPS];

    for (genvar j = 0; j < MAX_TAPS; j++)
    begin : g_cell
        localparam int NXT = (j + 1) % MAX_TAPS;
        cell_sel_t sel;

        assign sel.hit    = (slot == TAP_W'(j));
        assign sel.last   = (n_last == TAP_W'(j));
        assign sel.active = (TAP_W'(j) <= n_last);

        iqdf_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .sel    (sel),
            .wr_i   (wr_i),
            .wr_q   (wr_q),
            .next_i (cell_i[NXT]),
            .next_q (cell_q[NXT]),
            .head_i (cell_i[0]),
            .head_q (cell_q[0]),
            .i_val  (cell_i[j]),
            .q_val  (cell_q[j])
        );
    end

    assign head_i = cell_i[0];
    assign head_q = cell_q[0];

endmodule

@@ design/iqdf_dc.sv @@
// DC tracker of one rail: error against the running estimate, rounded error out,
// and estimate update by beta times the error over three steps. Depends on iqdf_pkg.
module iqdf_dc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [iqdf_pkg::BETA_W-1:0]   beta,
    input  iqdf_pkg::sample_t             sample,
    input  logic                          err_en,
    input  logic                          mul_en,
    input  logic                          commit,
    output iqdf_pkg::sample_t             err
);
    import iqdf_pkg::*;

    localparam int E_W   = DC_W + 1;
    localparam int P_W   = E_W + BETA_W + 1;
    localparam int NDC_W = DC_W + 3;

    localparam logic signed [NDC_W-1:0] DC_HI =
        NDC_W'(((1 << (SAMPLE_BITS - 1)) - 1) << DC_FRAC);
    localparam logic signed [NDC_W-1:0] DC_LO = -DC_HI - NDC_W'(1 << DC_FRAC);

    logic signed [DC_W-1:0]  dc_reg, dc_next;
    logic signed [E_W-1:0]   e_reg, e_next;
    logic signed [P_W-1:0]   prod_reg, prod_next;
    sample_t                 err_reg, err_next;
    logic signed [E_W:0]     e_rnd;
    logic signed [NDC_W-1:0] nd;

    always_comb
    begin
        e_next = $signed({sample[SAMPLE_BITS-1], sample, {DC_FRAC{1'b0}}})
               - $signed({dc_reg[DC_W-1], dc_reg});
        prod_next = e_reg * $signed({1'b0, beta});
        e_rnd = $signed({e_reg[E_W-1], e_reg}) + (E_W+1)'(1 << (DC_FRAC - 1));
        err_next = sat_sample(SAT_W'($signed(e_rnd[E_W:DC_FRAC])));
        nd = NDC_W'(dc_reg) + NDC_W'($signed(prod_reg[P_W-1:DC_FRAC]));
        if (nd > DC_HI)
            dc_next = DC_HI[DC_W-1:0];
        else if (nd < DC_LO)
            dc_next = DC_LO[DC_W-1:0];
        else
            dc_next = nd[DC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_reg <= '0;
        end
        else if (commit)
        begin
            dc_reg <= dc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (err_en)
        begin
            e_reg <= e_next;
        end
        if (mul_en)
        begin
            prod_reg <= prod_next;
            err_reg  <= err_next;
        end
    end

    assign err = err_reg;

endmodule

@@ design/iqdf_mac.sv @@
// Multiply-accumulate unit of one rail: tap register, product register, accumulator,
// and the rounding and saturation of the sum. Depends on iqdf_pkg.
module iqdf_mac (
    input  logic                clk,
    input  iqdf_pkg::mac_ctl_t  ctl,
    input  iqdf_pkg::sample_t   hist,
    input  iqdf_pkg::coef_t     coef,
    output iqdf_pkg::sample_t   result
);
    import iqdf_pkg::*;

    sample_t                  h_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W:0]    acc_rnd;
    sample_t                  res_reg;

    assign acc_rnd = $signed({acc_reg[ACC_W-1], acc_reg}) + (ACC_W+1)'(1 << (COEF_FRAC - 1));

    always_ff @(posedge clk)
    begin
        if (ctl.tap)
        begin
            h_reg <= hist;
        end
        if (ctl.mul)
        begin
            prod_reg <= h_reg * coef;
        end
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctl.acc)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (ctl.round)
        begin
            res_reg <= sat_sample(SAT_W'($signed(acc_rnd[ACC_W:COEF_FRAC])));
        end
    end

    assign result = res_reg;

endmodule
